>>> sv/rme_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: shared package
// Types, sizes and the arctangent table for the Euler angle pipeline.
// ----------------------------------------------------------------------------
package rme_pkg;

   localparam int IN_W       = 18;   // matrix entry width, signed Q1.16
   localparam int FRAC_W     = 16;
   localparam int ANG_W      = 16;   // output angle width
   localparam int ACC_W      = 32;   // CORDIC angle accumulator, pi = 2^31
   localparam int THR_W      = 17;
   localparam int PRE_SHIFT  = 12;
   localparam int CRD_STAGES = 31;
   localparam int CRD_W      = 34;   // CORDIC x and y datapath width
   localparam int SQ_STAGES  = 17;   // one root bit per stage
   localparam int SQ_N_W     = 2 * SQ_STAGES;
   localparam int SQ_REM_W   = 20;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(66);

   // Carried alongside the square root stages.
   typedef struct packed {
      logic                   lock;
      logic signed [IN_W-1:0] ry;
      logic signed [IN_W-1:0] rx;
      logic signed [IN_W-1:0] yy;
      logic signed [IN_W-1:0] yx;
      logic signed [IN_W-1:0] v;
   } side_type;

   // One digit-by-digit square root step.
   typedef struct packed {
      logic [SQ_STAGES-1:0] root;
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_N_W-1:0]    n;
   } sqrt_type;

   // One CORDIC vectoring lane.
   typedef struct packed {
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic [ACC_W-1:0]        acc;
   } lane_type;

   typedef logic [ACC_W-1:0] atan_tab_type [CRD_STAGES];

   // atan(2^-i), pi = 2^31.
   localparam atan_tab_type ATAN_TAB = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
   };

endpackage

>>> sv/rotation_matrix_to_euler_core.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles
// Converts a direction cosine matrix to Z-Y-X roll, pitch and yaw angles.
// ----------------------------------------------------------------------------
// The core takes one matrix word per clock while req_tready is high and
// returns one angle word per word, in order. Two front stages form the
// squares and the lock test, 17 stages extract the square root that turns
// asin into atan2, one stage pre-rotates, and three 31-stage CORDIC lanes
// run side by side before a final rounding register. The whole pipeline
// advances whenever the output register is empty or being taken, so
// req_tready drops only while a finished word waits on rsp_tready.
// Angles are binary, 32768 = pi; gimbal lock is flagged in rsp_tuser.
module rotation_matrix_to_euler_core
   import rme_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [16:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // m11, m12, m13, m21, m22, m23, m33 (18 bits each), zero pad
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // roll, pitch, yaw (16 bits each)
   output logic [47:0]  rsp_tdata,
   // gimbal_lock
   output logic [0:0]   rsp_tuser
);

   logic adv;

   // Threshold register.
   logic [THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // Input unpacking.
   logic signed [IN_W-1:0] m11, m12, m13, m21, m22, m23, m33;
   assign m11 = req_tdata[17:0];
   assign m12 = req_tdata[35:18];
   assign m13 = req_tdata[53:36];
   assign m21 = req_tdata[71:54];
   assign m22 = req_tdata[89:72];
   assign m23 = req_tdata[107:90];
   assign m33 = req_tdata[125:108];

   // Stage 1: squares and saturated asin operand.
   logic                   s1_vld_ff;
   logic signed [IN_W-1:0] s1_m11_ff, s1_m12_ff, s1_m21_ff, s1_m22_ff;
   logic signed [IN_W-1:0] s1_m23_ff, s1_m33_ff, s1_v_ff;
   logic [35:0]            s1_sq11_ff, s1_sq12_ff;
   logic [33:0]            s1_thr2_ff;
   logic [32:0]            s1_vsq_ff;
   logic signed [IN_W:0]   neg13;
   logic signed [IN_W-1:0] v_in;
   logic signed [35:0]     p11, p12;
   logic signed [35:0]     pv;

   always_comb begin
      neg13 = -(IN_W+1)'(m13);
      if (neg13 > (IN_W+1)'(65536)) begin
         v_in = IN_W'(65536);
      end else if (neg13 < -(IN_W+1)'(65536)) begin
         v_in = -IN_W'(65536);
      end else begin
         v_in = neg13[IN_W-1:0];
      end
      p11 = 36'(m11) * 36'(m11);
      p12 = 36'(m12) * 36'(m12);
      pv  = 36'(v_in) * 36'(v_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_m11_ff  <= m11;
         s1_m12_ff  <= m12;
         s1_m21_ff  <= m21;
         s1_m22_ff  <= m22;
         s1_m23_ff  <= m23;
         s1_m33_ff  <= m33;
         s1_v_ff    <= v_in;
         s1_sq11_ff <= p11;
         s1_sq12_ff <= p12;
         s1_vsq_ff  <= pv[32:0];
         s1_thr2_ff <= 34'(thr_ff) * 34'(thr_ff);
      end
   end

   // Stage 2: lock test, roll operand select, root radicand.
   logic     s2_vld_ff;
   side_type s2_side_ff;
   sqrt_type s2_sq_ff;
   logic [35:0] mag2;
   logic [32:0] rad;

   always_comb begin
      mag2 = s1_sq11_ff + s1_sq12_ff;
      rad  = 33'h1_0000_0000 - s1_vsq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_side_ff.lock <= (mag2 < 36'(s1_thr2_ff));
         if (mag2 < 36'(s1_thr2_ff)) begin
            s2_side_ff.ry <= s1_m21_ff;
            s2_side_ff.rx <= s1_m22_ff;
         end else begin
            s2_side_ff.ry <= s1_m23_ff;
            s2_side_ff.rx <= s1_m33_ff;
         end
         s2_side_ff.yy <= s1_m12_ff;
         s2_side_ff.yx <= s1_m11_ff;
         s2_side_ff.v  <= s1_v_ff;
         s2_sq_ff.root <= '0;
         s2_sq_ff.rem  <= '0;
         s2_sq_ff.n    <= {1'b0, rad};
      end
   end

   // Square root: one result bit per stage.
   logic     sq_vld_ff  [SQ_STAGES];
   side_type sq_side_ff [SQ_STAGES];
   sqrt_type sq_ff      [SQ_STAGES];

   function automatic sqrt_type sqrt_step(sqrt_type s);
      logic [SQ_REM_W-1:0] r2;
      logic [SQ_REM_W-1:0] trial;
      sqrt_type            o;
      r2    = {s.rem[SQ_REM_W-3:0], s.n[SQ_N_W-1 -: 2]};
      trial = SQ_REM_W'({s.root, 2'b01});
      o.n   = {s.n[SQ_N_W-3:0], 2'b00};
      if (r2 >= trial) begin
         o.rem  = r2 - trial;
         o.root = {s.root[SQ_STAGES-2:0], 1'b1};
      end else begin
         o.rem  = r2;
         o.root = {s.root[SQ_STAGES-2:0], 1'b0};
      end
      return o;
   endfunction

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k] <= (k == 0) ? s2_vld_ff : sq_vld_ff[(k == 0) ? 0 : k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (k == 0) begin
               sq_side_ff[k] <= s2_side_ff;
               sq_ff[k]      <= sqrt_step(s2_sq_ff);
            end else begin
               sq_side_ff[k] <= sq_side_ff[(k == 0) ? 0 : k-1];
               sq_ff[k]      <= sqrt_step(sq_ff[(k == 0) ? 0 : k-1]);
            end
         end
      end
   end

   // CORDIC pre-rotation into the right half plane.
   function automatic lane_type pre_rot(logic signed [IN_W-1:0] y,
                                        logic signed [IN_W-1:0] x);
      lane_type o;
      o.x   = CRD_W'(x) <<< PRE_SHIFT;
      o.y   = CRD_W'(y) <<< PRE_SHIFT;
      o.acc = '0;
      if (o.x < 0) begin
         o.x   = -o.x;
         o.y   = -o.y;
         o.acc = 32'h8000_0000;
      end
      return o;
   endfunction

   function automatic lane_type crd_step(lane_type s, int i);
      logic signed [CRD_W-1:0] dx;
      logic signed [CRD_W-1:0] dy;
      lane_type                o;
      dx = s.y >>> i;
      dy = s.x >>> i;
      if (s.y >= 0) begin
         o.x   = s.x + dx;
         o.y   = s.y - dy;
         o.acc = s.acc + ATAN_TAB[i];
      end else begin
         o.x   = s.x - dx;
         o.y   = s.y + dy;
         o.acc = s.acc - ATAN_TAB[i];
      end
      return o;
   endfunction

   logic                   ci_vld_ff;
   logic                   ci_lock_ff;
   lane_type               ci_lane_ff [3];
   logic signed [IN_W-1:0] c_root;

   assign c_root = IN_W'(sq_ff[SQ_STAGES-1].root);

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_vld_ff <= 1'b0;
      end else if (adv) begin
         ci_vld_ff <= sq_vld_ff[SQ_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ci_lock_ff    <= sq_side_ff[SQ_STAGES-1].lock;
         ci_lane_ff[0] <= pre_rot(sq_side_ff[SQ_STAGES-1].ry, sq_side_ff[SQ_STAGES-1].rx);
         ci_lane_ff[1] <= pre_rot(sq_side_ff[SQ_STAGES-1].v, c_root);
         ci_lane_ff[2] <= pre_rot(sq_side_ff[SQ_STAGES-1].yy, sq_side_ff[SQ_STAGES-1].yx);
      end
   end

   // CORDIC vectoring stages, three lanes in step.
   logic     cr_vld_ff  [CRD_STAGES];
   logic     cr_lock_ff [CRD_STAGES];
   lane_type cr_roll_ff [CRD_STAGES];
   lane_type cr_pit_ff  [CRD_STAGES];
   lane_type cr_yaw_ff  [CRD_STAGES];

   for (genvar i = 0; i < CRD_STAGES; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (reset) begin
            cr_vld_ff[i] <= 1'b0;
         end else if (adv) begin
            cr_vld_ff[i] <= (i == 0) ? ci_vld_ff : cr_vld_ff[(i == 0) ? 0 : i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (i == 0) begin
               cr_lock_ff[i] <= ci_lock_ff;
               cr_roll_ff[i] <= crd_step(ci_lane_ff[0], i);
               cr_pit_ff[i]  <= crd_step(ci_lane_ff[1], i);
               cr_yaw_ff[i]  <= crd_step(ci_lane_ff[2], i);
            end else begin
               cr_lock_ff[i] <= cr_lock_ff[(i == 0) ? 0 : i-1];
               cr_roll_ff[i] <= crd_step(cr_roll_ff[(i == 0) ? 0 : i-1], i);
               cr_pit_ff[i]  <= crd_step(cr_pit_ff[(i == 0) ? 0 : i-1], i);
               cr_yaw_ff[i]  <= crd_step(cr_yaw_ff[(i == 0) ? 0 : i-1], i);
            end
         end
      end
   end

   // Output register: round half up to the angle width.
   function automatic logic [ANG_W-1:0] to_angle(logic [ACC_W-1:0] acc);
      logic [ACC_W-1:0] r;
      r = acc + ACC_W'(1 << (ACC_W - ANG_W - 1));
      return r[ACC_W-1 -: ANG_W];
   endfunction

   logic             out_vld_ff;
   logic [ANG_W-1:0] roll_ff, pitch_ff, yaw_ff;
   logic             lock_ff;

   assign adv = !out_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= cr_vld_ff[CRD_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lock_ff <= cr_lock_ff[CRD_STAGES-1];
         roll_ff <= to_angle(cr_roll_ff[CRD_STAGES-1].acc);
         if (cr_lock_ff[CRD_STAGES-1]) begin
            pitch_ff <= to_angle(32'h4000_0000);
            yaw_ff   <= '0;
         end else begin
            pitch_ff <= to_angle(cr_pit_ff[CRD_STAGES-1].acc);
            yaw_ff   <= to_angle(cr_yaw_ff[CRD_STAGES-1].acc);
         end
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {yaw_ff, pitch_ff, roll_ff};
   assign rsp_tuser  = lock_ff;

   // Checks.
   a_lock_fixed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[47:32] == 16'h0000
                                   && rsp_tdata[31:16] == 16'h4000)
      else $error("lock word has wrong pitch or yaw");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready disagrees with output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule
